// ----- sv/wzam_pkg.sv -----
`default_nettype none
package wzam_pkg;
	localparam int unsigned CHANNELS = 4;
	localparam int unsigned DEPTH    = 256;
	localparam int unsigned CH_W     = 2;
	localparam int unsigned SLOT_W   = 8;
	localparam int unsigned FILL_W   = 9;
	localparam int unsigned ADDR_W   = CH_W + SLOT_W;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned MAG_W    = 17;
	localparam int unsigned Z_W      = 13;
	localparam int unsigned THR_W    = 12;
	localparam int unsigned SUM_W    = 25;
	localparam int unsigned SQ_W     = 39;
	localparam int unsigned A_W      = 26;
	localparam int unsigned D_W      = 47;
	localparam int unsigned R_W      = 65;
	localparam int unsigned QUO_W    = 25;
	localparam int unsigned K_W      = 13;
	localparam int unsigned MUL_A_W  = 32;
	localparam int unsigned MUL_B_W  = 25;
	localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;

	localparam logic [K_W-1:0]   Z_POS_MAX = 13'd4095;
	localparam logic [K_W-1:0]   Z_SAT     = 13'd4096;
	localparam logic [THR_W-1:0] WARN_RST  = 12'd512;
	localparam logic [THR_W-1:0] CRIT_RST  = 12'd768;

	localparam logic REG_WARN = 1'b0;
	localparam logic REG_CRIT = 1'b1;

	localparam logic [1:0] LVL_NOMINAL  = 2'd0;
	localparam logic [1:0] LVL_WARNING  = 2'd1;
	localparam logic [1:0] LVL_CRITICAL = 2'd2;

	function automatic logic [MAG_W-1:0] mag16(input logic signed [SAMPLE_W-1:0] x);
		logic signed [MAG_W-1:0] e;
		e = MAG_W'(x);
		return x[SAMPLE_W-1] ? MAG_W'(-e) : MAG_W'(e);
	endfunction
endpackage
`default_nettype wire

// ----- sv/windowed_zscore_anomaly_monitor_core.sv -----
// channel   handshake              payload
// in        in_valid / in_ready    channel_0_sample .. channel_3_sample
// out       out_valid / out_ready  channel_0_z .. channel_3_z, peak_abs_z, alarm_level, intervene
// cfg       cfg_write_en           cfg_index, cfg_data
//
// one word holds the block from the idle step that takes it to the finish step: per channel
// it uses the shared multiplier, then the divider and the square root, both skipped when
// the deviation or the variance term is zero
// a quotient that saturates skips the square root
// reset clears the window sums, the fill count and the write slot; the sample ram is not cleared
// a new word is taken while the last result waits; the sequencer holds only if that
// result is still untaken when the next one is ready
`default_nettype none
module windowed_zscore_anomaly_monitor_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [wzam_pkg::SAMPLE_W-1:0]   channel_0_sample,
	input  wire logic signed [wzam_pkg::SAMPLE_W-1:0]   channel_1_sample,
	input  wire logic signed [wzam_pkg::SAMPLE_W-1:0]   channel_2_sample,
	input  wire logic signed [wzam_pkg::SAMPLE_W-1:0]   channel_3_sample,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [wzam_pkg::Z_W-1:0]             channel_0_z,
	output logic signed [wzam_pkg::Z_W-1:0]             channel_1_z,
	output logic signed [wzam_pkg::Z_W-1:0]             channel_2_z,
	output logic signed [wzam_pkg::Z_W-1:0]             channel_3_z,
	output logic [wzam_pkg::Z_W-1:0]                    peak_abs_z,
	output logic [1:0]                                  alarm_level,
	output logic                                        intervene,
	input  wire logic                                   cfg_write_en,
	input  wire logic                                   cfg_index,
	input  wire logic [wzam_pkg::THR_W-1:0]             cfg_data
);
	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_RD   = 14'b00000000000010,
		ST_OLD  = 14'b00000000000100,
		ST_NEW  = 14'b00000000001000,
		ST_NV   = 14'b00000000010000,
		ST_AV   = 14'b00000000100000,
		ST_SS   = 14'b00000001000000,
		ST_QL   = 14'b00000010000000,
		ST_QH   = 14'b00000100000000,
		ST_DD   = 14'b00001000000000,
		ST_RR   = 14'b00010000000000,
		ST_WAIT = 14'b00100000000000,
		ST_ZO   = 14'b01000000000000,
		ST_FIN  = 14'b10000000000000
	} st_t;

	st_t                                       state_q;
	logic [wzam_pkg::THR_W-1:0]                warn_q;
	logic [wzam_pkg::THR_W-1:0]                crit_q;
	logic [wzam_pkg::SLOT_W-1:0]               slot_q;
	logic [wzam_pkg::FILL_W-1:0]               fill_q;
	logic                                      full_q;
	logic [wzam_pkg::FILL_W-1:0]               n_q;
	logic [wzam_pkg::CH_W-1:0]                 c_q;
	logic signed [wzam_pkg::SAMPLE_W-1:0]      v_q [wzam_pkg::CHANNELS];
	logic signed [wzam_pkg::SUM_W-1:0]         s_q [wzam_pkg::CHANNELS];
	logic [wzam_pkg::SQ_W-1:0]                 q_q [wzam_pkg::CHANNELS];
	logic signed [wzam_pkg::Z_W-1:0]           z_q [wzam_pkg::CHANNELS];
	logic [wzam_pkg::PROD_W-1:0]               p_q;
	logic signed [wzam_pkg::A_W-1:0]           a_q;
	logic [wzam_pkg::D_W-1:0]                  ss_q;
	logic [wzam_pkg::D_W-1:0]                  d_q;
	logic [wzam_pkg::R_W-1:0]                  r_q;
	logic                                      zero_q;
	logic [wzam_pkg::Z_W-1:0]                  peak_q;
	logic                                      out_valid_q;
	logic signed [wzam_pkg::Z_W-1:0]           oz_q [wzam_pkg::CHANNELS];
	logic [wzam_pkg::Z_W-1:0]                  opeak_q;
	logic [1:0]                                olvl_q;

	logic                                      accept;
	logic signed [wzam_pkg::SAMPLE_W-1:0]      rd_data;
	logic signed [wzam_pkg::SAMPLE_W-1:0]      old_eff;
	logic signed [wzam_pkg::SAMPLE_W-1:0]      v_cur;
	logic signed [wzam_pkg::SUM_W-1:0]         s_cur;
	logic [wzam_pkg::SUM_W-1:0]                s_abs;
	logic [wzam_pkg::A_W-1:0]                  a_abs;
	logic signed [wzam_pkg::A_W-1:0]           nv;
	logic [wzam_pkg::MUL_A_W-1:0]              mul_a;
	logic [wzam_pkg::MUL_B_W-1:0]              mul_b;
	logic [wzam_pkg::ADDR_W-1:0]               addr;
	logic                                      u_done;
	logic [wzam_pkg::K_W-1:0]                  u_k;
	logic [wzam_pkg::K_W-1:0]                  k;
	logic [wzam_pkg::K_W-1:0]                  k_pos;
	logic signed [wzam_pkg::Z_W-1:0]           z_new;
	logic [wzam_pkg::Z_W-1:0]                  az;
	logic                                      can_load;
	logic [1:0]                                lvl;

	assign accept   = in_valid && in_ready;
	assign in_ready = state_q == ST_IDLE;
	assign addr     = {c_q, slot_q};
	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		v_cur   = v_q[c_q];
		s_cur   = s_q[c_q];
		old_eff = full_q ? rd_data : '0;
		s_abs   = s_cur[wzam_pkg::SUM_W-1] ? wzam_pkg::SUM_W'(-s_cur) : wzam_pkg::SUM_W'(s_cur);
		a_abs   = a_q[wzam_pkg::A_W-1] ? wzam_pkg::A_W'(-a_q) : wzam_pkg::A_W'(a_q);
		nv      = v_cur[wzam_pkg::SAMPLE_W-1] ? -wzam_pkg::A_W'(p_q[23:0])
			: wzam_pkg::A_W'(p_q[23:0]);
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_OLD: begin
				mul_a = wzam_pkg::MUL_A_W'(wzam_pkg::mag16(old_eff));
				mul_b = wzam_pkg::MUL_B_W'(wzam_pkg::mag16(old_eff));
			end
			ST_NEW: begin
				mul_a = wzam_pkg::MUL_A_W'(wzam_pkg::mag16(v_cur));
				mul_b = wzam_pkg::MUL_B_W'(wzam_pkg::mag16(v_cur));
			end
			ST_NV: begin
				mul_a = wzam_pkg::MUL_A_W'(wzam_pkg::mag16(v_cur));
				mul_b = wzam_pkg::MUL_B_W'(n_q);
			end
			ST_AV: begin
				mul_a = wzam_pkg::MUL_A_W'(s_abs);
				mul_b = s_abs;
			end
			ST_SS: begin
				mul_a = q_q[c_q][31:0];
				mul_b = wzam_pkg::MUL_B_W'(n_q);
			end
			ST_QL: begin
				mul_a = wzam_pkg::MUL_A_W'(q_q[c_q][wzam_pkg::SQ_W-1:32]);
				mul_b = wzam_pkg::MUL_B_W'(n_q);
			end
			ST_QH: begin
				mul_a = wzam_pkg::MUL_A_W'(a_abs);
				mul_b = a_abs[wzam_pkg::MUL_B_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		k     = zero_q ? '0 : u_k;
		k_pos = (k > wzam_pkg::Z_POS_MAX) ? wzam_pkg::Z_POS_MAX : k;
		if (a_q[wzam_pkg::A_W-1]) begin
			z_new = wzam_pkg::Z_W'(-$signed({1'b0, k}));
			az    = k;
		end else begin
			z_new = $signed(k_pos);
			az    = k_pos;
		end
		if (peak_q > wzam_pkg::Z_W'(crit_q)) begin
			lvl = wzam_pkg::LVL_CRITICAL;
		end else if (peak_q > wzam_pkg::Z_W'(warn_q)) begin
			lvl = wzam_pkg::LVL_WARNING;
		end else begin
			lvl = wzam_pkg::LVL_NOMINAL;
		end
	end

	wzam_window_ram u_ram (
		.clk   (clk),
		.we    (state_q == ST_OLD),
		.waddr (addr),
		.wdata (v_cur),
		.re    (state_q == ST_RD),
		.raddr (addr),
		.rdata (rd_data)
	);

	wzam_root_div u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_RR && !(d_q == '0 || a_q == '0)),
		.r      (r_q),
		.d      (d_q),
		.done   (u_done),
		.k      (u_k)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			warn_q      <= wzam_pkg::WARN_RST;
			crit_q      <= wzam_pkg::CRIT_RST;
			slot_q      <= '0;
			fill_q      <= '0;
			c_q         <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < wzam_pkg::CHANNELS; i++) begin
				s_q[i] <= '0;
				q_q[i] <= '0;
			end
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					wzam_pkg::REG_WARN: warn_q <= cfg_data;
					wzam_pkg::REG_CRIT: crit_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						c_q     <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD:  state_q <= ST_OLD;
				ST_OLD: begin
					s_q[c_q] <= s_cur + wzam_pkg::SUM_W'(v_cur) - wzam_pkg::SUM_W'(old_eff);
					state_q  <= ST_NEW;
				end
				ST_NEW: begin
					q_q[c_q] <= q_q[c_q] - p_q[wzam_pkg::SQ_W-1:0];
					state_q  <= ST_NV;
				end
				ST_NV: begin
					q_q[c_q] <= q_q[c_q] + p_q[wzam_pkg::SQ_W-1:0];
					state_q  <= ST_AV;
				end
				ST_AV:  state_q <= ST_SS;
				ST_SS:  state_q <= ST_QL;
				ST_QL:  state_q <= ST_QH;
				ST_QH:  state_q <= ST_DD;
				ST_DD:  state_q <= ST_RR;
				ST_RR:  state_q <= (d_q == '0 || a_q == '0) ? ST_ZO : ST_WAIT;
				ST_WAIT: begin
					if (u_done) begin
						state_q <= ST_ZO;
					end
				end
				ST_ZO: begin
					if (c_q == wzam_pkg::CH_W'(wzam_pkg::CHANNELS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						slot_q      <= slot_q + 1'b1;
						if (!full_q) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				v_q[0] <= channel_0_sample;
				v_q[1] <= channel_1_sample;
				v_q[2] <= channel_2_sample;
				v_q[3] <= channel_3_sample;
				full_q <= fill_q == wzam_pkg::FILL_W'(wzam_pkg::DEPTH);
				n_q    <= (fill_q == wzam_pkg::FILL_W'(wzam_pkg::DEPTH)) ? fill_q
					: fill_q + 1'b1;
				peak_q <= '0;
			end
			ST_AV: a_q  <= nv - wzam_pkg::A_W'(s_cur);
			ST_SS: ss_q <= p_q[wzam_pkg::D_W-1:0];
			ST_QL: d_q  <= wzam_pkg::D_W'(p_q[40:0]);
			ST_QH: d_q  <= d_q + {p_q[14:0], 32'b0};
			ST_DD: begin
				d_q <= d_q - ss_q;
				r_q <= {p_q[48:0], 16'b0};
			end
			ST_RR: zero_q <= d_q == '0 || a_q == '0;
			ST_ZO: begin
				z_q[c_q] <= z_new;
				if (az > peak_q) begin
					peak_q <= az;
				end
			end
			ST_FIN: begin
				if (can_load) begin
					for (int i = 0; i < wzam_pkg::CHANNELS; i++) begin
						oz_q[i] <= z_q[i];
					end
					opeak_q <= peak_q;
					olvl_q  <= lvl;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign channel_0_z = oz_q[0];
	assign channel_1_z = oz_q[1];
	assign channel_2_z = oz_q[2];
	assign channel_3_z = oz_q[3];
	assign peak_abs_z  = opeak_q;
	assign alarm_level = olvl_q;
	assign intervene   = olvl_q == wzam_pkg::LVL_CRITICAL;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= wzam_pkg::FILL_W'(wzam_pkg::DEPTH))
		else $error("fill count beyond window depth");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RD)
		else $error("accepted word did not start processing");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside finish step");

	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q <= wzam_pkg::Z_SAT)
		else $error("peak z beyond saturation");
endmodule
`default_nettype wire

// ----- sv/wzam_window_ram.sv -----
`default_nettype none
module wzam_window_ram (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [wzam_pkg::ADDR_W-1:0]          waddr,
	input  wire logic signed [wzam_pkg::SAMPLE_W-1:0] wdata,
	input  wire logic                                 re,
	input  wire logic [wzam_pkg::ADDR_W-1:0]          raddr,
	output logic signed [wzam_pkg::SAMPLE_W-1:0]      rdata
);
	logic signed [wzam_pkg::SAMPLE_W-1:0] mem [(1 << wzam_pkg::ADDR_W)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- sv/wzam_root_div.sv -----
`default_nettype none
module wzam_root_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [wzam_pkg::R_W-1:0]    r,
	input  wire logic [wzam_pkg::D_W-1:0]    d,
	output logic                             done,
	output logic [wzam_pkg::K_W-1:0]         k
);
	typedef enum logic [3:0] {
		U_IDLE = 4'b0001,
		U_DIV  = 4'b0010,
		U_SQRT = 4'b0100,
		U_DONE = 4'b1000
	} ust_t;

	localparam int unsigned TW = wzam_pkg::R_W + 7;

	ust_t                          st_q;
	logic [wzam_pkg::R_W-1:0]      rem_q;
	logic [wzam_pkg::D_W-1:0]      dv_q;
	logic [wzam_pkg::QUO_W-1:0]    quo_q;
	logic [4:0]                    cnt_q;
	logic [23:0]                   op_q;
	logic [23:0]                   res_q;
	logic [23:0]                   one_q;
	logic [wzam_pkg::K_W-1:0]      k_q;

	logic [TW-1:0]                 trial;
	logic [TW-1:0]                 rem_ext;
	logic [TW-1:0]                 diff;
	logic                          ge;
	logic [wzam_pkg::QUO_W-1:0]    quo_nx;
	logic [24:0]                   sum;
	logic                          sq_ge;
	logic [23:0]                   res_nx;

	always_comb begin
		trial   = TW'(dv_q) << cnt_q;
		rem_ext = TW'(rem_q);
		ge      = rem_ext >= trial;
		diff    = rem_ext - trial;
		quo_nx  = quo_q | (ge ? (wzam_pkg::QUO_W'(1) << cnt_q) : '0);
		sum     = {1'b0, res_q} + {1'b0, one_q};
		sq_ge   = {1'b0, op_q} >= sum;
		res_nx  = sq_ge ? ((res_q >> 1) + one_q) : (res_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= U_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				U_IDLE: begin
					if (start) begin
						cnt_q <= 5'(wzam_pkg::QUO_W - 1);
						st_q  <= U_DIV;
					end
				end
				U_DIV: begin
					if (cnt_q == '0) begin
						cnt_q <= 5'd11;
						st_q  <= quo_nx[wzam_pkg::QUO_W-1] ? U_DONE : U_SQRT;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				U_SQRT: begin
					if (cnt_q == '0) begin
						st_q <= U_DONE;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				U_DONE: begin
					st_q <= U_IDLE;
				end
				default: begin
					st_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			U_IDLE: begin
				rem_q <= r;
				dv_q  <= d;
				quo_q <= '0;
			end
			U_DIV: begin
				if (ge) begin
					rem_q <= diff[wzam_pkg::R_W-1:0];
				end
				quo_q <= quo_nx;
				op_q  <= quo_nx[23:0];
				res_q <= '0;
				one_q <= 24'd1 << 22;
				k_q   <= wzam_pkg::Z_SAT;
			end
			U_SQRT: begin
				if (sq_ge) begin
					op_q <= op_q - sum[23:0];
				end
				res_q <= res_nx;
				one_q <= one_q >> 2;
				k_q   <= res_nx[wzam_pkg::K_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign done = st_q == U_DONE;
	assign k    = k_q;
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [wzam_pkg::Z_W-1:0] z[wzam_pkg::CHANNELS];
		logic [wzam_pkg::Z_W-1:0]        peak;
		logic [1:0]                      level;
		logic                            intervene;
	} zscore_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [wzam_pkg::SAMPLE_W-1:0] s0 = '0, s1 = '0, s2 = '0, s3 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [wzam_pkg::Z_W-1:0] z0, z1, z2, z3;
	logic [wzam_pkg::Z_W-1:0] peak_abs_z;
	logic [1:0] alarm_level;
	logic intervene;
	logic cfg_write_en = 1'b0;
	logic cfg_index = wzam_pkg::REG_WARN;
	logic [wzam_pkg::THR_W-1:0] cfg_data = '0;

	windowed_zscore_anomaly_monitor_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.channel_0_sample(s0), .channel_1_sample(s1),
		.channel_2_sample(s2), .channel_3_sample(s3),
		.out_valid(out_valid), .out_ready(out_ready),
		.channel_0_z(z0), .channel_1_z(z1), .channel_2_z(z2), .channel_3_z(z3),
		.peak_abs_z(peak_abs_z), .alarm_level(alarm_level), .intervene(intervene),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// predictor state
	shortint      hist[wzam_pkg::CHANNELS][wzam_pkg::DEPTH];
	longint       run_sum[wzam_pkg::CHANNELS];
	longint       run_sq[wzam_pkg::CHANNELS];
	int           slot_ptr, fill_cnt;
	logic [wzam_pkg::THR_W-1:0] warn_thr, crit_thr;
	zscore_word_t pending_z[$];
	int           errors = 0;
	bit           idle_on = 1'b1;

	function automatic int scaled_z(longint v, longint s, longint q, int n);
		longint a, am;
		logic [127:0] d, rhs, lhs;
		int lo, hi, mid;
		a = longint'(n) * v - s;
		am = a < 0 ? -a : a;
		d = 128'(longint'(n) * q - s * s);
		rhs = (128'(am) * 128'(am)) << 16;
		lo = 0;
		hi = 4096;
		if (d == 0 || am == 0)
			return 0;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			lhs = 128'(mid) * 128'(mid) * d;
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		if (a < 0)
			return -lo;
		return lo > 4095 ? 4095 : lo;
	endfunction

	function automatic zscore_word_t predict_zscores(shortint v[wzam_pkg::CHANNELS]);
		zscore_word_t r;
		bit full;
		int zi, az, pk;
		full = fill_cnt >= wzam_pkg::DEPTH;
		pk = 0;
		for (int c = 0; c < wzam_pkg::CHANNELS; c++) begin
			if (full) begin
				run_sum[c] -= hist[c][slot_ptr];
				run_sq[c] -= longint'(hist[c][slot_ptr]) * hist[c][slot_ptr];
			end
			hist[c][slot_ptr] = v[c];
			run_sum[c] += v[c];
			run_sq[c] += longint'(v[c]) * v[c];
		end
		slot_ptr = (slot_ptr + 1) % wzam_pkg::DEPTH;
		if (!full)
			fill_cnt++;
		for (int c = 0; c < wzam_pkg::CHANNELS; c++) begin
			zi = scaled_z(v[c], run_sum[c], run_sq[c], fill_cnt);
			az = zi < 0 ? -zi : zi;
			if (az > pk)
				pk = az;
			r.z[c] = wzam_pkg::Z_W'(zi);
		end
		r.peak = wzam_pkg::Z_W'(pk);
		if (pk > crit_thr)
			r.level = wzam_pkg::LVL_CRITICAL;
		else if (pk > warn_thr)
			r.level = wzam_pkg::LVL_WARNING;
		else
			r.level = wzam_pkg::LVL_NOMINAL;
		r.intervene = r.level == wzam_pkg::LVL_CRITICAL;
		return r;
	endfunction

	task automatic send_word(shortint a, shortint b, shortint c, shortint d);
		shortint v[wzam_pkg::CHANNELS];
		int gap;
		gap = (idle_on && $urandom_range(3) == 0) ? $urandom_range(15, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		s0 <= a;
		s1 <= b;
		s2 <= c;
		s3 <= d;
		do @(posedge clk); while (!in_ready);
		v[0] = a;
		v[1] = b;
		v[2] = c;
		v[3] = d;
		pending_z.push_back(predict_zscores(v));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_z.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_thresholds(logic [wzam_pkg::THR_W-1:0] w,
		logic [wzam_pkg::THR_W-1:0] c);
		cfg_write_en <= 1'b1;
		cfg_index <= wzam_pkg::REG_WARN;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= wzam_pkg::REG_CRIT;
		cfg_data <= c;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		warn_thr = w;
		crit_thr = c;
	endtask

	// sink stall
	initial begin
		int burst;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(4) == 0) begin
				burst = $urandom_range(15, 1);
				out_ready <= 1'b0;
				repeat (burst) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		zscore_word_t e;
		logic signed [wzam_pkg::Z_W-1:0] got[wzam_pkg::CHANNELS];
		if (arst_n && out_valid && out_ready) begin
			got[0] = z0;
			got[1] = z1;
			got[2] = z2;
			got[3] = z3;
			if (pending_z.size() == 0) begin
				$display("%t unexpected word, none pending", $realtime);
				errors++;
			end else begin
				e = pending_z.pop_front();
				for (int c = 0; c < wzam_pkg::CHANNELS; c++)
					if (got[c] !== e.z[c]) begin
						$display("%t channel %0d z exp %0d got %0d", $realtime, c, e.z[c], got[c]);
						errors++;
					end
				if (peak_abs_z !== e.peak) begin
					$display("%t peak exp %0d got %0d", $realtime, e.peak, peak_abs_z);
					errors++;
				end
				if (alarm_level !== e.level) begin
					$display("%t level exp %0d got %0d", $realtime, e.level, alarm_level);
					errors++;
				end
				if (intervene !== e.intervene) begin
					$display("%t intervene exp %0d got %0d", $realtime, e.intervene, intervene);
					errors++;
				end
			end
		end
	end

	task automatic test_directed;
		send_word(16'sh7fff, -16'sd32768, 0, -1);
		send_word(16'sh7fff, -16'sd32768, 0, -1);
		send_word(-16'sd32768, 16'sh7fff, 1, 0);
		send_word(0, 0, 0, 0);
		for (int i = 0; i < 10; i++)
			send_word(5, -5, 100, 0);
		send_word(16'sh7fff, -16'sd32768, 16'sh5555, 16'shaaaa);
		for (int i = 0; i < 6; i++)
			send_word(shortint'(i * 3), 7, -200, 16'sh0100);
		send_word(-16'sd32768, 16'sh7fff, -16'sd32768, 16'sh7fff);
		drain();
	endtask

	task automatic test_threshold_extremes;
		set_thresholds('0, '0);
		for (int i = 0; i < 8; i++)
			send_word(shortint'($urandom), shortint'($urandom), 3, shortint'($urandom_range(4)));
		drain();
		set_thresholds(12'd4095, 12'd4095);
		for (int i = 0; i < 8; i++)
			send_word(shortint'($urandom), 0, shortint'($urandom), 16'sh7fff);
		drain();
		set_thresholds(12'd900, 12'd300);
		for (int i = 0; i < 8; i++)
			send_word(10, shortint'($urandom_range(20)), -10, shortint'($urandom));
		drain();
	endtask

	task automatic test_random_stream(int count);
		shortint base[wzam_pkg::CHANNELS];
		shortint v[wzam_pkg::CHANNELS];
		int span, mode;
		for (int c = 0; c < wzam_pkg::CHANNELS; c++)
			base[c] = shortint'(int'($urandom_range(2000)) - 1000);
		span = $urandom_range(200, 1);
		for (int i = 0; i < count; i++) begin
			for (int c = 0; c < wzam_pkg::CHANNELS; c++) begin
				mode = $urandom_range(99);
				if (mode < 65)
					v[c] = base[c] + shortint'($urandom_range(2 * span)) - shortint'(span);
				else if (mode < 80)
					v[c] = shortint'(int'(base[c]) + int'($urandom_range(30000)) - 15000);
				else if (mode < 85)
					v[c] = $urandom_range(1) ? 16'sh7fff : -16'sd32768;
				else
					v[c] = shortint'($urandom);
			end
			send_word(v[0], v[1], v[2], v[3]);
		end
		drain();
	endtask

	task automatic test_window_wrap;
		logic [wzam_pkg::THR_W-1:0] w;
		for (int p = 0; p < 5; p++) begin
			w = wzam_pkg::THR_W'($urandom_range(1200));
			set_thresholds(w, wzam_pkg::THR_W'($urandom_range(1500)));
			if (p == 4)
				idle_on = 1'b0;
			test_random_stream(290);
		end
	endtask

	initial begin
		for (int c = 0; c < wzam_pkg::CHANNELS; c++) begin
			run_sum[c] = 0;
			run_sq[c] = 0;
		end
		slot_ptr = 0;
		fill_cnt = 0;
		warn_thr = wzam_pkg::WARN_RST;
		crit_thr = wzam_pkg::CRIT_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold_extremes();
		test_window_wrap();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#50ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
sv/wzam_pkg.sv
sv/wzam_window_ram.sv
sv/wzam_root_div.sv
sv/windowed_zscore_anomaly_monitor_core.sv
verif/tb.sv
